/* rtl/token_index_hash_map_assert.svh */
// Assertion macros for the token index hash map.
`ifndef TOKEN_INDEX_HASH_MAP_ASSERT_SVH
`define TOKEN_INDEX_HASH_MAP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define TIHM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("token_index_hash_map: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define TIHM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("token_index_hash_map: next-cycle check failed");

`endif

/* rtl/tihm_pkg.sv */
package tihm_pkg;

   localparam int DEF_BUCKETS     = 257;
   localparam int DEF_ENTRIES     = 256;
   localparam int DEF_TOKEN_BYTES = 7;

   localparam int CMD_BITS    = 2;
   localparam int TOKEN_BITS  = 56;
   localparam int INDEX_BITS  = 8;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DISPATCH,
      BK_COMPARE,
      BK_SWEEP
   } back_state_type;

   // back end to top level: queue pop and bucket sweep after reset
   typedef struct packed {
      logic pop;
      logic init;
   } back_status_type;

endpackage

/* rtl/token_index_hash_map.sv */
// The back end sets the pace: an insert links its new entry at the bucket head, a lookup
// compares chain entries one by one until a hit or the chain end, a clear resets every head
// (one head a cycle), and a full-pool insert or an unused code is answered straight from idle.
// It takes the next word only once it is back in idle; each chain step waits on a read.
// Up to 4 words wait in the front pipeline and queue; busy rises when all 4 slots are taken.
// Reset: synchronous; a sweep then empties every bucket with busy held high.
`include "token_index_hash_map_assert.svh"

module token_index_hash_map import tihm_pkg::*; #(
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int ENTRIES     = DEF_ENTRIES,
   parameter int TOKEN_BYTES = DEF_TOKEN_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_BITS-1:0]   req_cmd,
   input  logic [TOKEN_BITS-1:0] req_token,
   input  logic [INDEX_BITS-1:0] req_palette_index,
   output logic                  rsp_strobe,
   output logic                  rsp_found,
   output logic [INDEX_BITS-1:0] rsp_result_index,
   output logic                  rsp_status
);

   localparam int TW   = 8 * TOKEN_BYTES;
   localparam int BW   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
   localparam int QW   = CMD_BITS + TW + INDEX_BITS + BW;
   localparam int PENW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PENW-1:0] PEN_FULL = PENW'(QUEUE_DEPTH);

   logic                  accept;
   logic [PENW-1:0]       pending_ff, pending_in;

   // front end to queue
   logic                  push;
   logic [CMD_BITS-1:0]   f_cmd;
   logic [TW-1:0]         f_token;
   logic [INDEX_BITS-1:0] f_index;
   logic [BW-1:0]         f_bucket;

   // queue to back end
   logic                  q_valid;
   logic [QW-1:0]         q_dout;
   logic [CMD_BITS-1:0]   q_cmd;
   logic [TW-1:0]         q_token;
   logic [INDEX_BITS-1:0] q_index;
   logic [BW-1:0]         q_bucket;

   back_status_type       back_st;

   // Credit count covers words in the front pipeline and the queue, so the
   // queue can never overflow. Drop it by one on each back-end pop.
   assign accept     = start && !busy;
   assign pending_in = pending_ff + PENW'(accept) - PENW'(back_st.pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Hold off new words while all slots are in use or the head sweep after
   // reset is still running.
   assign busy = (pending_ff == PEN_FULL) || back_st.init;

   // Front: normalize the token, take its byte sum and reduce it modulo the
   // bucket count over three pipeline stages.
   tihm_front #(
      .BUCKETS     (BUCKETS),
      .TOKEN_BYTES (TOKEN_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cmd           (req_cmd),
      .token         (req_token),
      .palette_index (req_palette_index),
      .push          (push),
      .op_cmd        (f_cmd),
      .op_token      (f_token),
      .op_index      (f_index),
      .op_bucket     (f_bucket)
   );

   // Queue: decouple the classified words from the chain walk.
   tihm_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   ({f_cmd, f_token, f_index, f_bucket}),
      .pop   (back_st.pop),
      .valid (q_valid),
      .dout  (q_dout)
   );

   assign {q_cmd, q_token, q_index, q_bucket} = q_dout;

   // Back: read the bucket head, link new entries at the head, walk chains
   // for lookups and sweep the heads on clear.
   tihm_back #(
      .BUCKETS     (BUCKETS),
      .ENTRIES     (ENTRIES),
      .TOKEN_BYTES (TOKEN_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_token          (q_token),
      .q_index          (q_index),
      .q_bucket         (q_bucket),
      .status           (back_st),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_result_index (rsp_result_index),
      .rsp_status       (rsp_status)
   );

   // Credits never exceed the slot count.
   `TIHM_ASSERT_IMP(a_pending_bound, clock, reset, 1'b1, pending_ff <= PEN_FULL)
   // A pop only ever takes a word that was counted in.
   `TIHM_ASSERT_IMP(a_pop_has_credit, clock, reset, back_st.pop, pending_ff != '0)
   // No word gets in during the head sweep after reset.
   `TIHM_ASSERT_IMP(a_init_blocks, clock, reset, back_st.init, busy && !accept)
   // A hit is only reported with a strobe and never together with table_full.
   `TIHM_ASSERT_IMP(a_found_on_strobe, clock, reset, rsp_found, rsp_strobe && !rsp_status)
   // An accepted word stays counted until the back end pops it.
   `TIHM_ASSERT_NXT(a_accept_counted, clock, reset, accept && !back_st.pop, pending_ff != '0)

endmodule

/* rtl/tihm_ram.sv */
module tihm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tihm_queue.sv */
module tihm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] dout
);

   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign valid = (count_ff != '0);
   assign dout  = mem_ff[rd_ptr_ff];

endmodule

/* rtl/tihm_front.sv */
module tihm_front import tihm_pkg::*; #(
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int TOKEN_BYTES = DEF_TOKEN_BYTES
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         accept,
   input  logic [CMD_BITS-1:0]                          cmd,
   input  logic [TOKEN_BITS-1:0]                        token,
   input  logic [INDEX_BITS-1:0]                        palette_index,
   output logic                                         push,
   output logic [CMD_BITS-1:0]                          op_cmd,
   output logic [8*TOKEN_BYTES-1:0]                     op_token,
   output logic [INDEX_BITS-1:0]                        op_index,
   output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] op_bucket
);

   localparam int TW   = 8 * TOKEN_BYTES;
   localparam int BW   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
   localparam int SW   = $clog2(TOKEN_BYTES * 255 + 1);
   // ceil reciprocal; shift wide enough that sum / BUCKETS floors exactly
   localparam int RSH  = SW + BW;
   localparam int unsigned RECIP = ((1 << RSH) + BUCKETS - 1) / BUCKETS;
   localparam int PRW  = SW + RSH + 1;
   localparam int MW   = SW + BW;

   logic [TW-1:0]  norm_c;
   logic [SW-1:0]  sum_c;
   logic           alive;
   logic [PRW-1:0] prod_c;
   logic [MW-1:0]  diff_c;

   logic                  v1_ff, v2_ff, v3_ff;
   logic [CMD_BITS-1:0]   cmd1_ff, cmd2_ff, cmd3_ff;
   logic [TW-1:0]         tok1_ff, tok2_ff, tok3_ff;
   logic [INDEX_BITS-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic [SW-1:0]         sum1_ff, sum2_ff;
   logic [SW-1:0]         quot2_ff;
   logic [BW-1:0]         bucket3_ff;

   // zero every byte from the first zero byte on, and sum what remains
   always_comb begin
      alive  = 1'b1;
      norm_c = '0;
      sum_c  = '0;
      for (int i = 0; i < TOKEN_BYTES; i++) begin
         alive = alive && (token[8*i +: 8] != 8'd0);
         norm_c[8*i +: 8] = alive ? token[8*i +: 8] : 8'd0;
         sum_c = sum_c + SW'(norm_c[8*i +: 8]);
      end
   end

   assign prod_c = PRW'(sum1_ff) * PRW'(RECIP);
   assign diff_c = MW'(sum2_ff) - MW'(quot2_ff) * MW'(BUCKETS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd1_ff    <= cmd;
      tok1_ff    <= norm_c;
      idx1_ff    <= palette_index;
      sum1_ff    <= sum_c;
      cmd2_ff    <= cmd1_ff;
      tok2_ff    <= tok1_ff;
      idx2_ff    <= idx1_ff;
      sum2_ff    <= sum1_ff;
      quot2_ff   <= prod_c[RSH +: SW];
      cmd3_ff    <= cmd2_ff;
      tok3_ff    <= tok2_ff;
      idx3_ff    <= idx2_ff;
      bucket3_ff <= diff_c[BW-1:0];
   end

   assign push      = v3_ff;
   assign op_cmd    = cmd3_ff;
   assign op_token  = tok3_ff;
   assign op_index  = idx3_ff;
   assign op_bucket = bucket3_ff;

endmodule

/* rtl/tihm_back.sv */
module tihm_back import tihm_pkg::*; #(
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int ENTRIES     = DEF_ENTRIES,
   parameter int TOKEN_BYTES = DEF_TOKEN_BYTES
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         q_valid,
   input  logic [CMD_BITS-1:0]                          q_cmd,
   input  logic [8*TOKEN_BYTES-1:0]                     q_token,
   input  logic [INDEX_BITS-1:0]                        q_index,
   input  logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] q_bucket,
   output back_status_type                              status,
   output logic                                         rsp_strobe,
   output logic                                         rsp_found,
   output logic [INDEX_BITS-1:0]                        rsp_result_index,
   output logic                                         rsp_status
);

   localparam int TW = 8 * TOKEN_BYTES;
   localparam int BW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
   localparam int EW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
   localparam int LW = $clog2(ENTRIES + 1);
   localparam int DW = LW + INDEX_BITS + TW;
   localparam logic [LW-1:0] NO_ENTRY    = LW'(ENTRIES);
   localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

   back_state_type        state_ff, state_in;
   logic [LW-1:0]         used_ff, used_in;
   logic [BW-1:0]         sweep_ff, sweep_in;
   logic                  init_ff, init_in;
   cmd_type               cmd_ff, cmd_in;
   logic [TW-1:0]         tok_ff, tok_in;
   logic [INDEX_BITS-1:0] pidx_ff, pidx_in;
   logic [BW-1:0]         bucket_ff, bucket_in;

   logic                  strobe_ff, strobe_in;
   logic                  found_ff, found_in;
   logic [INDEX_BITS-1:0] ridx_ff, ridx_in;
   logic                  stat_ff, stat_in;

   logic                  pop;
   logic                  head_wr_en;
   logic [BW-1:0]         head_wr_addr;
   logic [LW-1:0]         head_wr_data;
   logic [LW-1:0]         head_rd_data;
   logic                  ent_wr_en;
   logic [EW-1:0]         ent_rd_addr;
   logic [DW-1:0]         ent_wr_data;
   logic [DW-1:0]         ent_rd_data;

   cmd_type               cmd_q;
   logic [TW-1:0]         ent_tok;
   logic [INDEX_BITS-1:0] ent_idx;
   logic [LW-1:0]         ent_link;
   logic                  hit;
   logic                  head_empty;
   logic                  link_empty;
   logic                  pool_full;

   assign cmd_q      = cmd_type'(q_cmd);
   assign ent_tok    = ent_rd_data[TW-1:0];
   assign ent_idx    = ent_rd_data[TW +: INDEX_BITS];
   assign ent_link   = ent_rd_data[TW+INDEX_BITS +: LW];
   assign hit        = (ent_tok == tok_ff);
   assign head_empty = (head_rd_data == NO_ENTRY);
   assign link_empty = (ent_link == NO_ENTRY);
   assign pool_full  = (used_ff == NO_ENTRY);

   tihm_ram #(
      .WIDTH (LW),
      .DEPTH (BUCKETS)
   ) u_heads (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_addr (q_bucket),
      .rd_data (head_rd_data)
   );

   tihm_ram #(
      .WIDTH (DW),
      .DEPTH (ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (used_ff[EW-1:0]),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               unique case (cmd_q)
                  CMD_INSERT: state_in = pool_full ? BK_IDLE : BK_DISPATCH;
                  CMD_LOOKUP: state_in = BK_DISPATCH;
                  CMD_CLEAR:  state_in = BK_SWEEP;
                  default:    state_in = BK_IDLE;
               endcase
            end
         end
         BK_DISPATCH: begin
            if (cmd_ff == CMD_INSERT || head_empty) begin
               state_in = BK_IDLE;
            end else begin
               state_in = BK_COMPARE;
            end
         end
         BK_COMPARE: begin
            if (hit || link_empty) begin
               state_in = BK_IDLE;
            end
         end
         BK_SWEEP: begin
            if (sweep_ff == LAST_BUCKET) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop          = 1'b0;
      used_in      = used_ff;
      sweep_in     = sweep_ff;
      init_in      = init_ff;
      cmd_in       = cmd_ff;
      tok_in       = tok_ff;
      pidx_in      = pidx_ff;
      bucket_in    = bucket_ff;
      head_wr_en   = 1'b0;
      head_wr_addr = sweep_ff;
      head_wr_data = NO_ENTRY;
      ent_wr_en    = 1'b0;
      ent_wr_data  = {head_rd_data, pidx_ff, tok_ff};
      ent_rd_addr  = head_rd_data[EW-1:0];
      strobe_in    = 1'b0;
      found_in     = 1'b0;
      ridx_in      = '0;
      stat_in      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               pop       = 1'b1;
               cmd_in    = cmd_q;
               tok_in    = q_token;
               pidx_in   = q_index;
               bucket_in = q_bucket;
               unique case (cmd_q)
                  CMD_INSERT: begin
                     if (pool_full) begin
                        strobe_in = 1'b1;
                        stat_in   = 1'b1;
                     end
                  end
                  CMD_LOOKUP: begin
                  end
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     used_in  = '0;
                  end
                  default: strobe_in = 1'b1;
               endcase
            end
         end
         BK_DISPATCH: begin
            if (cmd_ff == CMD_INSERT) begin
               ent_wr_en    = 1'b1;
               head_wr_en   = 1'b1;
               head_wr_addr = bucket_ff;
               head_wr_data = used_ff;
               used_in      = used_ff + 1'b1;
               strobe_in    = 1'b1;
            end else if (head_empty) begin
               strobe_in = 1'b1;
            end
         end
         BK_COMPARE: begin
            ent_rd_addr = ent_link[EW-1:0];
            if (hit) begin
               strobe_in = 1'b1;
               found_in  = 1'b1;
               ridx_in   = ent_idx;
            end else if (link_empty) begin
               strobe_in = 1'b1;
            end
         end
         BK_SWEEP: begin
            head_wr_en = 1'b1;
            sweep_in   = sweep_ff + 1'b1;
            if (sweep_ff == LAST_BUCKET) begin
               init_in   = 1'b0;
               strobe_in = !init_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_SWEEP;
         used_ff   <= '0;
         sweep_ff  <= '0;
         init_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         sweep_ff  <= sweep_in;
         init_ff   <= init_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      tok_ff    <= tok_in;
      pidx_ff   <= pidx_in;
      bucket_ff <= bucket_in;
      found_ff  <= found_in;
      ridx_ff   <= ridx_in;
      stat_ff   <= stat_in;
   end

   assign status.pop       = pop;
   assign status.init      = init_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_found        = found_ff;
   assign rsp_result_index = ridx_ff;
   assign rsp_status       = stat_ff;

endmodule

/* sim/tb_token_index_hash_map.sv */
`timescale 1ns / 100ps

module tb_token_index_hash_map;
   import tihm_pkg::*;

   localparam int NBUCK = DEF_BUCKETS;
   localparam int NENT  = DEF_ENTRIES;
   localparam int NTOKB = DEF_TOKEN_BYTES;

   // The spare command code: no state change, all-zero answer.
   localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [TOKEN_BITS-1:0] token;
      logic [INDEX_BITS-1:0] pidx;
   } word_type;

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] index;
      logic                  status;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_BITS-1:0]   req_cmd = '0;
   logic [TOKEN_BITS-1:0] req_token = '0;
   logic [INDEX_BITS-1:0] req_palette_index = '0;
   logic                  rsp_strobe;
   logic                  rsp_found;
   logic [INDEX_BITS-1:0] rsp_result_index;
   logic                  rsp_status;

   token_index_hash_map dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_token         (req_token),
      .req_palette_index (req_palette_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_result_index  (rsp_result_index),
      .rsp_status        (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the table: chain heads, entry pool, pool fill level.
   // An empty head or link holds NENT.
   // ------------------------------------------------------------------
   int                    shadow_heads  [NBUCK];
   logic [TOKEN_BITS-1:0] shadow_tokens [NENT];
   logic [INDEX_BITS-1:0] shadow_index  [NENT];
   int                    shadow_link   [NENT];
   int                    shadow_used = 0;

   word_type  words_to_send [$];   // stimulus not yet offered to the block
   reply_type answers_due   [$];   // answers owed for accepted words, oldest first
   int        fail_count = 0;

   function automatic void clear_shadow();
      for (int i = 0; i < NBUCK; i++) shadow_heads[i] = NENT;
      shadow_used = 0;
   endfunction

   // Drop every byte from the first zero byte on.
   function automatic logic [TOKEN_BITS-1:0] trim_token(logic [TOKEN_BITS-1:0] raw);
      logic [TOKEN_BITS-1:0] kept;
      bit ended;
      kept  = '0;
      ended = 1'b0;
      for (int i = 0; i < NTOKB; i++) begin
         if (raw[8*i +: 8] == 8'd0) ended = 1'b1;
         if (!ended) kept[8*i +: 8] = raw[8*i +: 8];
      end
      return kept;
   endfunction

   function automatic int bucket_of_token(logic [TOKEN_BITS-1:0] tok);
      int sum;
      sum = 0;
      for (int i = 0; i < TOKEN_BITS / 8; i++) sum += int'(tok[8*i +: 8]);
      return sum % NBUCK;
   endfunction

   // Apply one word to the shadow table and return the answer it earns.
   function automatic reply_type hash_map_answer(logic [CMD_BITS-1:0] cmd,
                                                 logic [TOKEN_BITS-1:0] raw,
                                                 logic [INDEX_BITS-1:0] pidx);
      reply_type             r;
      logic [TOKEN_BITS-1:0] tok;
      int                    b;
      int                    cur;
      int                    steps;
      r   = '0;
      tok = trim_token(raw);
      b   = bucket_of_token(tok);
      case (cmd)
         CMD_INSERT: begin
            if (shadow_used >= NENT) begin
               r.status = 1'b1;
            end else begin
               shadow_tokens[shadow_used] = tok;
               shadow_index[shadow_used]  = pidx;
               shadow_link[shadow_used]   = shadow_heads[b];
               shadow_heads[b]            = shadow_used;
               shadow_used++;
            end
         end
         CMD_LOOKUP: begin
            cur   = shadow_heads[b];
            steps = 0;
            while (cur < NENT && steps < NENT && !r.found) begin
               if (shadow_tokens[cur] == tok) begin
                  r.found = 1'b1;
                  r.index = shadow_index[cur];
               end else begin
                  cur = shadow_link[cur];
                  steps++;
               end
            end
         end
         CMD_CLEAR: clear_shadow();
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void queue_word(logic [CMD_BITS-1:0] c, logic [TOKEN_BITS-1:0] t,
                                      logic [INDEX_BITS-1:0] p);
      word_type w;
      w.cmd   = c;
      w.token = t;
      w.pidx  = p;
      words_to_send.push_back(w);
   endfunction

   function automatic logic [TOKEN_BITS-1:0] any_token();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TOKEN_BITS-1:0];
   endfunction

   // Clean token of len nonzero bytes.
   function automatic logic [TOKEN_BITS-1:0] random_token(int len);
      logic [TOKEN_BITS-1:0] t;
      t = '0;
      for (int i = 0; i < len; i++) t[8*i +: 8] = 8'($urandom_range(1, 255));
      return t;
   endfunction

   // Clean token of len nonzero bytes (two if one byte cannot reach hot) whose byte sum lands in bucket hot.
   function automatic logic [TOKEN_BITS-1:0] token_in_bucket(int hot, int len);
      logic [TOKEN_BITS-1:0] t;
      int partial;
      int last;
      if (len < 2 && (hot == 0 || hot > 255)) len = 2;
      do begin
         t       = random_token(len - 1);
         partial = bucket_of_token(t);
         last    = (hot - partial + NBUCK) % NBUCK;
      end while (last == 0 || last > 255);
      t[8*(len-1) +: 8] = 8'(last);
      return t;
   endfunction

   // Fill the bytes past the first zero byte with junk; the block must ignore it.
   function automatic logic [TOKEN_BITS-1:0] with_junk(logic [TOKEN_BITS-1:0] tok);
      logic [63:0] m;
      int k;
      k = NTOKB;
      for (int i = NTOKB - 1; i >= 0; i--) if (tok[8*i +: 8] == 8'd0) k = i;
      if (k >= NTOKB - 1) return tok;
      m = (64'h1 << (8 * (k + 1))) - 64'h1;
      return (tok & m[TOKEN_BITS-1:0]) | (any_token() & ~m[TOKEN_BITS-1:0]);
   endfunction

   function automatic void log_failure(string what);
      if (fail_count < 10) $display("%0t ns: %s", $time, what);
      fail_count++;
   endfunction

   // ------------------------------------------------------------------
   // Driver: offer words from the queue in bursts, predict on acceptance.
   // ------------------------------------------------------------------
   int       gap_left   = 0;
   int       burst_left = 1;
   word_type next_word;
   logic     go;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         clear_shadow();
      end else begin
         // A word moves at this edge: book its answer before anything else.
         if (start && !busy)
            answers_due.push_back(hash_map_answer(req_cmd, req_token, req_palette_index));
         // Hold the current word while the block is busy; otherwise pick the next one.
         if (!(start && busy)) begin
            go = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (words_to_send.size() > 0) begin
               next_word = words_to_send.pop_front();
               req_cmd           <= next_word.cmd;
               req_token         <= next_word.token;
               req_palette_index <= next_word.pidx;
               go = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  // Mostly short bursts, now and then a long stretch without gaps.
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                           : $urandom_range(1, 10);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            start <= go;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every strobe must match the oldest answer owed.
   // ------------------------------------------------------------------
   reply_type want;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (answers_due.size() == 0) begin
            log_failure("result strobe with no answer pending");
         end else begin
            want = answers_due.pop_front();
            if (rsp_found !== want.found || rsp_result_index !== want.index ||
                rsp_status !== want.status)
               log_failure($sformatf(
                  "mismatch: expected found=%0b index=%0d status=%0b, got found=%b index=%0d status=%b",
                  want.found, want.index, want.status,
                  rsp_found, rsp_result_index, rsp_status));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      logic [TOKEN_BITS-1:0] vocab  [$];
      logic [TOKEN_BITS-1:0] filled [$];
      logic [TOKEN_BITS-1:0] tk;
      int hot;
      int roll;
      int pick;
      int n_ops;
      int fills;
      int spare_bytes;

      fills = 0;

      // Directed: empty token, all-ones token, wraparound collisions in one
      // bucket, shadowing by a newer insert, junk after a zero byte, the spare
      // code, and clear.
      queue_word(CMD_LOOKUP, '0, 8'h5A);
      queue_word(CMD_INSERT, '0, 8'hFF);
      queue_word(CMD_LOOKUP, 56'hA5C3_0000_0000_00, 8'h00);
      queue_word(CMD_INSERT, {TOKEN_BITS{1'b1}}, 8'h00);
      queue_word(CMD_LOOKUP, {TOKEN_BITS{1'b1}}, 8'hFF);
      queue_word(CMD_INSERT, 56'h01, 8'h11);
      queue_word(CMD_INSERT, 56'h8181, 8'h22);
      queue_word(CMD_LOOKUP, 56'h01, 8'h00);
      queue_word(CMD_LOOKUP, 56'h8181, 8'h00);
      queue_word(CMD_LOOKUP, 56'h8280, 8'h00);
      queue_word(CMD_INSERT, 56'h01, 8'h33);
      queue_word(CMD_LOOKUP, 56'hFF00_0000_0000_01 | 56'h00FF_EE00, 8'h00);
      queue_word(CMD_INSERT, 56'hAA55_0000_636261, 8'h44);
      queue_word(CMD_LOOKUP, 56'h636261, 8'h00);
      queue_word(CMD_LOOKUP, 56'h63626100_000000, 8'h00);
      queue_word(CMD_SPARE, any_token(), 8'hC3);
      queue_word(CMD_LOOKUP, 56'h01, 8'h00);
      queue_word(CMD_CLEAR, any_token(), 8'hFF);
      queue_word(CMD_LOOKUP, 56'h01, 8'h00);
      queue_word(CMD_LOOKUP, {TOKEN_BITS{1'b1}}, 8'h00);
      queue_word(CMD_INSERT, 56'h0102_0304_0506_07, 8'h80);
      queue_word(CMD_LOOKUP, 56'h0102_0304_0506_07, 8'h00);

      // Random segments until the item budget is spent.
      while (words_to_send.size() < 1950) begin
         roll = $urandom_range(0, 99);
         if ((fills == 0 && words_to_send.size() > 400) || (roll < 4 && fills < 3)) begin
            // Pack the whole pool into one bucket, overflow it, then walk the
            // full chain with misses and deep hits.
            fills++;
            hot = $urandom_range(0, NBUCK - 1);
            filled.delete();
            queue_word(CMD_CLEAR, any_token(), 8'($urandom));
            for (int i = 0; i < NENT + $urandom_range(1, 6); i++) begin
               tk = token_in_bucket(hot, $urandom_range(1, NTOKB));
               if (i < 8) filled.push_back(tk);
               queue_word(CMD_INSERT, tk, 8'($urandom));
            end
            for (int i = 0; i < 8; i++) begin
               if (i % 2 == 0) tk = token_in_bucket(hot, $urandom_range(1, NTOKB));
               else            tk = with_junk(filled[$urandom_range(0, filled.size() - 1)]);
               queue_word(CMD_LOOKUP, tk, 8'($urandom));
            end
         end else if (roll < 85) begin
            // Well-formed work on a small set of tokens, many sharing a bucket.
            if ($urandom_range(0, 1) == 0) queue_word(CMD_CLEAR, any_token(), 8'($urandom));
            hot = $urandom_range(0, NBUCK - 1);
            vocab.delete();
            for (int i = 0; i < $urandom_range(4, 12); i++) begin
               pick = $urandom_range(0, 19);
               if (pick == 0)     vocab.push_back('0);
               else if (pick < 11) vocab.push_back(token_in_bucket(hot, $urandom_range(1, NTOKB)));
               else               vocab.push_back(random_token($urandom_range(1, NTOKB)));
            end
            n_ops = $urandom_range(10, 40);
            for (int i = 0; i < n_ops; i++) begin
               roll = $urandom_range(0, 99);
               tk   = vocab[$urandom_range(0, vocab.size() - 1)];
               if ($urandom_range(0, 3) == 0) tk = with_junk(tk);
               if (roll < 45)
                  queue_word(CMD_INSERT, tk, 8'($urandom));
               else if (roll < 90)
                  queue_word(CMD_LOOKUP, tk, 8'($urandom));
               else if (roll < 96)
                  queue_word(CMD_LOOKUP, token_in_bucket(hot, $urandom_range(1, NTOKB)),
                             8'($urandom));
               else
                  queue_word(CMD_CLEAR, any_token(), 8'($urandom));
            end
         end else begin
            // Noise: any code, fully random token bits.
            spare_bytes = $urandom_range(5, 15);
            for (int i = 0; i < spare_bytes; i++)
               queue_word(2'($urandom_range(0, 3)), any_token(), 8'($urandom));
         end
      end

      // Release reset; the block then sweeps its buckets
      // with busy high, which the driver simply waits out.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Drain: every word offered and accepted, every answer returned.
      while (words_to_send.size() != 0 || start || answers_due.size() != 0)
         @(posedge clock);
      // Hold long enough for a stray extra result (a clear takes the longest).
      repeat (NBUCK + 32) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb_token_index_hash_map: done, clean");
      end else begin
         $display("tb_token_index_hash_map: done, errors");
      end
      $finish;
   end

   // Watchdog: the slowest correct run is a few ms; give it several times that.
   initial begin
      #30_000_000;
      $display("tb_token_index_hash_map: done, errors");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/tihm_pkg.sv
rtl/tihm_ram.sv
rtl/tihm_queue.sv
rtl/tihm_front.sv
rtl/tihm_back.sv
rtl/token_index_hash_map.sv
sim/tb_token_index_hash_map.sv
